[src/wss_pkg.sv]
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants of the step sequencer
// Sizes, action and register codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int MAX_STEPS   = 32;
    localparam int CHANNELS    = 4;
    localparam int PLAY_CH     = 3;
    localparam int STEP_W      = $clog2(MAX_STEPS);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int ADDR_W      = CH_W + STEP_W;
    localparam int CNT_W       = STEP_W + 1;
    localparam int PITCH_W     = 15;
    localparam int MAG_W       = 14;
    localparam int QUO_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PITCH_LIMIT = 12000;
    localparam int QUANT_RECIP = 5243;
    localparam int QUANT_SHIFT = 19;
    localparam int QUANT_STEP  = 100;
    localparam int QUANT_HALF  = 50;

    localparam logic [CH_W-1:0]  STAGE     = CH_W'(CHANNELS - 1);
    localparam logic [CNT_W-1:0] XFER_LAST = CNT_W'(MAX_STEPS);
    localparam logic [CNT_W-1:0] OUT_LAST  = CNT_W'(PLAY_CH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOSTEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASTE_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd6;

    // action codes
    localparam logic [3:0] ACT_TICK   = 4'd0;
    localparam logic [3:0] ACT_RISE   = 4'd1;
    localparam logic [3:0] ACT_FALL   = 4'd2;
    localparam logic [3:0] ACT_RESET  = 4'd3;
    localparam logic [3:0] ACT_RUN    = 4'd4;
    localparam logic [3:0] ACT_COPY   = 4'd5;
    localparam logic [3:0] ACT_PASTE  = 4'd6;
    localparam logic [3:0] ACT_NEXT   = 4'd7;
    localparam logic [3:0] ACT_GATE   = 4'd8;
    localparam logic [3:0] ACT_WRITE  = 4'd9;
    localparam logic [3:0] ACT_LEFT   = 4'd10;
    localparam logic [3:0] ACT_RIGHT  = 4'd11;
    localparam logic [3:0] ACT_WINDOW = 4'd12;

    // pending paste modes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_CLOCK = 2'd1;
    localparam logic [1:0] PEND_WRAP  = 2'd2;
    localparam logic [1:0] PASTE_NOW  = 2'd0;

    localparam logic [5:0]        RST_STEP_COUNT = 6'd32;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF    = 16'd48;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_XFER, S_TGL_RD, S_TGL_WR,
        S_POST, S_WR_RD, S_WR_WR, S_OUT, S_HOLD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PRE, OP_XFER, OP_TGL_RD, OP_TGL_WR,
        OP_POST, OP_WR_RD, OP_WR_WR, OP_OUT, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic need_xfer;
        logic need_tgl;
        logic need_wr;
        logic out_free;
    } t_stat;

    // quotient of (mag + 50) / 100 by reciprocal multiply
    function automatic logic [QUO_W-1:0] quant_quo(input logic [MAG_W-1:0] mag);
        logic [MAG_W+QUANT_SHIFT-7:0] prod;
        prod = (MAG_W+QUANT_SHIFT-6)'(mag + MAG_W'(QUANT_HALF))
             * (MAG_W+QUANT_SHIFT-6)'(QUANT_RECIP);
        return prod[QUANT_SHIFT +: QUO_W];
    endfunction

endpackage

[src/wss_ctrl.sv]
// ----------------------------------------------------------------------------
// wss_ctrl: sequencing controller
// Walks each request through its phases and drives the datapath with
// one command per cycle, counting memory sweeps and output reads.
// ----------------------------------------------------------------------------
module wss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  wss_pkg::t_stat i_stat,
    output wss_pkg::t_cmd  o_cmd
);
    import wss_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_late, n_late;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_late  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_late  <= n_late;
        end
    end

    always_comb begin
        n_state = r_state;
        n_late  = r_late;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_PRE;
            end
            S_PRE: begin
                n_late = 1'b0;
                if (i_stat.need_xfer)     n_state = S_XFER;
                else if (i_stat.need_tgl) n_state = S_TGL_RD;
                else                      n_state = S_POST;
            end
            S_XFER: begin
                if (r_cnt == XFER_LAST) n_state = r_late ? S_OUT : S_POST;
            end
            S_TGL_RD: n_state = S_TGL_WR;
            S_TGL_WR: n_state = S_POST;
            S_POST: begin
                n_late = 1'b1;
                if (i_stat.need_xfer)    n_state = S_XFER;
                else if (i_stat.need_wr) n_state = S_WR_RD;
                else                     n_state = S_OUT;
            end
            S_WR_RD: n_state = S_WR_WR;
            S_WR_WR: n_state = S_OUT;
            S_OUT: begin
                if (r_cnt == OUT_LAST) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_cnt = (n_state == r_state) ? r_cnt + 1'b1 : '0;
    end

    always_comb begin
        o_ready    = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.cnt  = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = OP_LOAD;
            end
            S_PRE:    o_cmd.op = OP_PRE;
            S_XFER:   o_cmd.op = OP_XFER;
            S_TGL_RD: o_cmd.op = OP_TGL_RD;
            S_TGL_WR: o_cmd.op = OP_TGL_WR;
            S_POST:   o_cmd.op = OP_POST;
            S_WR_RD:  o_cmd.op = OP_WR_RD;
            S_WR_WR:  o_cmd.op = OP_WR_WR;
            S_OUT:    o_cmd.op = OP_OUT;
            S_HOLD: begin
                if (i_stat.out_free) o_cmd.op = OP_EMIT;
            end
            default:  o_cmd.op = OP_NONE;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_PRE))
        else $error("accepted request did not start");
    a_xfer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XFER) |-> (r_cnt <= XFER_LAST))
        else $error("sweep count overrun");
    a_tgl_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TGL_RD) |=> (r_state == S_TGL_WR))
        else $error("gate toggle lost its write");
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_cnt <= OUT_LAST))
        else $error("output read count overrun");
`endif

endmodule

[src/wss_dpath.sv]
// ----------------------------------------------------------------------------
// wss_dpath: sequencer datapath
// Configuration, step indices, pitch and gate stores, clipboard,
// quantiser and the output register, stepped by controller commands.
// ----------------------------------------------------------------------------
module wss_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wss_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [3:0]                          i_action,
    input  logic [2:0]                          i_button_index,
    input  logic signed [wss_pkg::PITCH_W-1:0]  i_pitch_in,
    input  logic                                i_gate_in_connected,
    input  logic                                i_gate_in_high,
    input  wss_pkg::t_cmd                       i_cmd,
    output wss_pkg::t_stat                      o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_a,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_b,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_c,
    output logic                                o_gate_out_a,
    output logic                                o_gate_out_b,
    output logic                                o_gate_out_c,
    output logic [4:0]                          o_play_step,
    output logic [4:0]                          o_staging_step,
    output logic [1:0]                          o_selected_channel,
    output logic                                o_is_running,
    output logic                                o_paste_waiting,
    output logic                                o_edit_allowed
);
    import wss_pkg::*;

    // configuration
    logic [5:0]        r_step_count;
    logic              r_quant, r_auto, r_mon, r_restart;
    logic [1:0]        r_ptime;
    logic [HOLD_W-1:0] r_holdcfg;

    // latched request
    logic [3:0]                 r_act;
    logic [2:0]                 r_btn;
    logic signed [PITCH_W-1:0]  r_pin;
    logic                       r_gconn, r_ghigh;
    logic [QUO_W-1:0]           r_quo;
    logic signed [PITCH_W-1:0]  r_qpin;

    // sequencer state
    logic [STEP_W-1:0] r_play, n_play, r_stage, n_stage;
    logic [CH_W-1:0]   r_ch, n_ch, r_pch, n_pch, r_xch, n_xch;
    logic              r_run, n_run, r_clk, n_clk, r_xdir, n_xdir;
    logic [1:0]        r_pmode, n_pmode;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [ADDR_W-1:0] r_wa, n_wa;

    // stores
    logic [PITCH_W-1:0] r_pmem [CHANNELS*MAX_STEPS];
    logic               r_gmem [CHANNELS*MAX_STEPS];
    logic [CHANNELS*MAX_STEPS-1:0] r_sval;
    logic [PITCH_W-1:0] r_cpmem [MAX_STEPS];
    logic               r_cgmem [MAX_STEPS];
    logic [MAX_STEPS-1:0] r_cval;
    logic [PITCH_W-1:0] r_srd_p, r_crd_p;
    logic               r_srd_g, r_crd_g;

    // captured and registered results
    logic signed [PITCH_W-1:0] r_op [PLAY_CH];
    logic                      r_og [PLAY_CH];
    logic                      r_ovalid;

    // combinational helpers
    logic [5:0]              n_act_steps;
    logic [STEP_W-1:0]       nm1, pc, sc, sel, sel_nxt, sel_prv, np, base, gidx;
    logic [5:0]              win;
    logic                    staging, can_edit;
    logic [HOLD_W-1:0]       hval;
    logic signed [PITCH_W-1:0] pin_sat;
    logic [MAG_W-1:0]        mag, qmag;
    logic [ADDR_W-1:0]       srd_addr, swr_addr;
    logic                    s_we, c_we;
    logic [PITCH_W-1:0]      swr_p;
    logic                    swr_g;
    logic [STEP_W-1:0]       crd_addr, cwr_addr;
    logic [1:0]              cap_k;
    logic                    need_xfer, need_tgl, need_wr;

    function automatic logic [STEP_W-1:0] step_next(input logic [STEP_W-1:0] v,
                                                    input logic [5:0] n);
        logic [5:0] w;
        w = 6'(v) + 6'd1;
        return (w >= n) ? '0 : STEP_W'(w);
    endfunction

    assign n_act_steps = (r_step_count == 6'd0) ? 6'd1
                       : (r_step_count > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : r_step_count;
    assign nm1     = STEP_W'(n_act_steps - 6'd1);
    assign pc      = (6'(r_play)  >= n_act_steps) ? nm1 : r_play;
    assign sc      = (6'(r_stage) >= n_act_steps) ? nm1 : r_stage;
    assign staging = (r_ch == STAGE);
    assign can_edit = !r_run || staging;
    assign sel     = staging ? sc : pc;
    assign sel_nxt = step_next(sel, n_act_steps);
    assign sel_prv = (sel == '0) ? nm1 : sel - 1'b1;
    assign win     = {r_btn, sel[2:0]};
    assign np      = step_next(pc, n_act_steps);
    assign base    = staging ? r_stage : r_play;
    assign gidx    = {base[STEP_W-1:3], r_btn};
    assign hval    = (r_act == ACT_RESET) ? r_holdcfg : r_hold;

    assign pin_sat = (i_pitch_in > PITCH_W'(PITCH_LIMIT)) ? PITCH_W'(PITCH_LIMIT)
                   : (i_pitch_in < -PITCH_W'(PITCH_LIMIT)) ? -PITCH_W'(PITCH_LIMIT)
                   : i_pitch_in;
    assign mag  = r_pin[PITCH_W-1] ? MAG_W'(-r_pin) : MAG_W'(r_pin);
    assign qmag = MAG_W'(16'(r_quo) * 16'(QUANT_STEP));

    always_comb begin
        n_play  = r_play;
        n_stage = r_stage;
        n_ch    = r_ch;
        n_run   = r_run;
        n_pmode = r_pmode;
        n_pch   = r_pch;
        n_hold  = r_hold;
        n_clk   = r_clk;
        n_xdir  = r_xdir;
        n_xch   = r_xch;
        n_wa    = r_wa;
        need_xfer = 1'b0;
        need_tgl  = 1'b0;
        need_wr   = 1'b0;
        case (i_cmd.op)
            OP_PRE: begin
                case (r_act)
                    ACT_RUN: begin
                        n_run = !r_run;
                        if (!r_run && r_restart) begin
                            n_play  = '0;
                            n_stage = '0;
                        end
                        n_hold = r_holdcfg;
                    end
                    ACT_COPY: begin
                        n_pmode   = PEND_NONE;
                        n_xdir    = 1'b0;
                        n_xch     = r_ch;
                        need_xfer = 1'b1;
                    end
                    ACT_PASTE: begin
                        if (r_ptime == PASTE_NOW || staging) begin
                            n_pmode   = PEND_NONE;
                            n_xdir    = 1'b1;
                            n_xch     = r_ch;
                            need_xfer = 1'b1;
                        end else begin
                            n_pmode = r_ptime[1] ? PEND_WRAP : PEND_CLOCK;
                            n_pch   = r_ch;
                        end
                    end
                    ACT_NEXT: n_ch = staging ? '0 : r_ch + 1'b1;
                    ACT_GATE: begin
                        n_wa     = {r_ch, gidx};
                        need_tgl = (6'(gidx) < n_act_steps);
                    end
                    default: ;
                endcase
            end
            OP_POST: begin
                n_play  = pc;
                n_stage = sc;
                case (r_act)
                    ACT_WRITE: begin
                        n_wa    = {r_ch, sel};
                        need_wr = can_edit;
                    end
                    ACT_LEFT: begin
                        if (can_edit) begin
                            if (staging) n_stage = sel_prv;
                            else         n_play  = sel_prv;
                        end
                    end
                    ACT_RIGHT: begin
                        if (can_edit) begin
                            if (staging) n_stage = sel_nxt;
                            else         n_play  = sel_nxt;
                        end
                    end
                    ACT_WINDOW: begin
                        if (can_edit) begin
                            if (staging) n_stage = (win >= n_act_steps) ? nm1 : STEP_W'(win);
                            else         n_play  = (win >= n_act_steps) ? nm1 : STEP_W'(win);
                        end
                    end
                    ACT_RISE: begin
                        if (!r_clk) begin
                            n_clk = 1'b1;
                            if (r_run && r_hold == '0) begin
                                n_play = np;
                                if (r_pmode == PEND_CLOCK ||
                                    (r_pmode == PEND_WRAP && np == '0)) begin
                                    n_pmode   = PEND_NONE;
                                    n_xdir    = 1'b1;
                                    n_xch     = r_pch;
                                    need_xfer = 1'b1;
                                end
                            end
                        end
                    end
                    ACT_FALL: n_clk = 1'b0;
                    ACT_RESET: begin
                        n_play  = '0;
                        n_stage = '0;
                        n_pmode = PEND_NONE;
                        n_clk   = 1'b0;
                    end
                    default: ;
                endcase
                n_hold = (hval != '0) ? hval - 1'b1 : '0;
            end
            OP_WR_WR: begin
                if (r_auto) begin
                    if (staging) n_stage = step_next(r_stage, n_act_steps);
                    else         n_play  = step_next(r_play, n_act_steps);
                end
            end
            default: ;
        endcase
    end

    assign o_stat.need_xfer = need_xfer;
    assign o_stat.need_tgl  = need_tgl;
    assign o_stat.need_wr   = need_wr;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    // memory port selection
    always_comb begin
        srd_addr = r_wa;
        swr_addr = r_wa;
        s_we     = 1'b0;
        swr_p    = r_srd_p;
        swr_g    = r_srd_g;
        crd_addr = i_cmd.cnt[STEP_W-1:0];
        cwr_addr = STEP_W'(i_cmd.cnt - 1'b1);
        c_we     = 1'b0;
        case (i_cmd.op)
            OP_XFER: begin
                srd_addr = {r_xch, i_cmd.cnt[STEP_W-1:0]};
                swr_addr = {r_xch, cwr_addr};
                swr_p    = r_crd_p;
                swr_g    = r_crd_g;
                s_we     = r_xdir && (i_cmd.cnt != '0);
                c_we     = !r_xdir && (i_cmd.cnt != '0);
            end
            OP_TGL_WR: begin
                s_we  = 1'b1;
                swr_g = !r_srd_g;
            end
            OP_WR_WR: begin
                s_we  = 1'b1;
                swr_p = r_qpin;
                swr_g = r_gconn ? r_ghigh : r_srd_g;
            end
            OP_OUT: srd_addr = {i_cmd.cnt[CH_W-1:0], r_play};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_pmem[swr_addr] <= swr_p;
            r_gmem[swr_addr] <= swr_g;
        end
        if (c_we) begin
            r_cpmem[cwr_addr] <= r_srd_p;
            r_cgmem[cwr_addr] <= r_srd_g;
        end
        r_srd_p <= r_sval[srd_addr] ? r_pmem[srd_addr] : '0;
        r_srd_g <= r_sval[srd_addr] ? r_gmem[srd_addr] : 1'b1;
        r_crd_p <= r_cval[crd_addr] ? r_cpmem[crd_addr] : '0;
        r_crd_g <= r_cval[crd_addr] ? r_cgmem[crd_addr] : 1'b1;
    end

    // request latch, quantiser stages, output capture
    assign cap_k = 2'(i_cmd.cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_act   <= i_action;
            r_btn   <= i_button_index;
            r_pin   <= pin_sat;
            r_gconn <= i_gate_in_connected;
            r_ghigh <= i_gate_in_high;
        end
        if (i_cmd.op == OP_PRE) r_quo <= quant_quo(mag);
        if (i_cmd.op == OP_POST) begin
            if (!r_quant)              r_qpin <= r_pin;
            else if (r_pin[PITCH_W-1]) r_qpin <= -$signed({1'b0, qmag});
            else                       r_qpin <= $signed({1'b0, qmag});
        end
        if (i_cmd.op == OP_OUT && i_cmd.cnt != '0) begin
            r_op[cap_k] <= (r_run || r_mon) ? r_srd_p : r_qpin;
            r_og[cap_k] <= r_run ? (r_clk && r_srd_g) : (r_ch == CH_W'(cap_k));
        end
        if (i_cmd.op == OP_EMIT) begin
            o_pitch_out_a      <= r_op[0];
            o_pitch_out_b      <= r_op[1];
            o_pitch_out_c      <= r_op[2];
            o_gate_out_a       <= r_og[0];
            o_gate_out_b       <= r_og[1];
            o_gate_out_c       <= r_og[2];
            o_play_step        <= 5'(r_play);
            o_staging_step     <= 5'(r_stage);
            o_selected_channel <= 2'(r_ch);
            o_is_running       <= r_run;
            o_paste_waiting    <= (r_pmode != PEND_NONE);
            o_edit_allowed     <= can_edit;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= RST_STEP_COUNT;
            r_quant      <= 1'b1;
            r_auto       <= 1'b1;
            r_ptime      <= PASTE_NOW;
            r_mon        <= 1'b0;
            r_restart    <= 1'b0;
            r_holdcfg    <= RST_HOLDOFF;
            r_play       <= '0;
            r_stage      <= '0;
            r_ch         <= '0;
            r_run        <= 1'b1;
            r_pmode      <= PEND_NONE;
            r_pch        <= '0;
            r_hold       <= RST_HOLDOFF;
            r_clk        <= 1'b0;
            r_xdir       <= 1'b0;
            r_xch        <= '0;
            r_wa         <= '0;
            r_sval       <= '0;
            r_cval       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_COUNT: r_step_count <= i_cfg_data[5:0];
                    CFG_QUANTIZE:   r_quant      <= i_cfg_data[0];
                    CFG_AUTOSTEP:   r_auto       <= i_cfg_data[0];
                    CFG_PASTE_TIME: r_ptime      <= i_cfg_data[1:0];
                    CFG_MONITOR:    r_mon        <= i_cfg_data[0];
                    CFG_RESTART:    r_restart    <= i_cfg_data[0];
                    CFG_HOLDOFF:    r_holdcfg    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_play  <= n_play;
            r_stage <= n_stage;
            r_ch    <= n_ch;
            r_run   <= n_run;
            r_pmode <= n_pmode;
            r_pch   <= n_pch;
            r_hold  <= n_hold;
            r_clk   <= n_clk;
            r_xdir  <= n_xdir;
            r_xch   <= n_xch;
            r_wa    <= n_wa;
            if (s_we) r_sval[swr_addr] <= 1'b1;
            if (c_we) r_cval[cwr_addr] <= 1'b1;
            if (i_cmd.op == OP_EMIT)  r_ovalid <= 1'b1;
            else if (i_out_ready)     r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

[src/writable_step_sequencer.sv]
// ----------------------------------------------------------------------------
// writable_step_sequencer: four-channel 32-step event sequencer
// Each request is one event (tick, clock edge, reset, run toggle, copy,
// paste, channel, gate toggle, write, left, right, window); each gives
// one result with three pitches, three gates and status.
//
// Input channel i_valid/o_ready, output channel o_valid/i_ready.
// Configuration registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must write them only while no request is in
// flight, since the block itself does not enforce it. A write or a
// gate toggle that is carried out adds a read and a write of the store
// (neither when it is refused or out of range); a copy, an immediate
// paste or a clock edge that releases a deferred paste adds a sweep.
// A new request is taken in the cycle after its result is registered,
// so requests do not overlap in the controller.
// The result waits in an output register: a stalled receiver holds it
// while the next request is taken and worked up to the output stage.
// Synchronous reset restores register defaults, stops nothing (the
// sequencer comes up running) and marks all stored steps as pitch zero
// with gate set at once, with no clearing pass.
// ----------------------------------------------------------------------------
module writable_step_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [3:0]                          i_action,
    input  logic [2:0]                          i_button_index,
    input  logic signed [wss_pkg::PITCH_W-1:0]  i_pitch_in,
    input  logic                                i_gate_in_connected,
    input  logic                                i_gate_in_high,
    input  logic                                i_cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wss_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_a,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_b,
    output logic signed [wss_pkg::PITCH_W-1:0]  o_pitch_out_c,
    output logic                                o_gate_out_a,
    output logic                                o_gate_out_b,
    output logic                                o_gate_out_c,
    output logic [4:0]                          o_play_step,
    output logic [4:0]                          o_staging_step,
    output logic [1:0]                          o_selected_channel,
    output logic                                o_is_running,
    output logic                                o_paste_waiting,
    output logic                                o_edit_allowed
);
    import wss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wss_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_action            (i_action),
        .i_button_index      (i_button_index),
        .i_pitch_in          (i_pitch_in),
        .i_gate_in_connected (i_gate_in_connected),
        .i_gate_in_high      (i_gate_in_high),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_out_ready         (i_ready),
        .o_out_valid         (o_valid),
        .o_pitch_out_a       (o_pitch_out_a),
        .o_pitch_out_b       (o_pitch_out_b),
        .o_pitch_out_c       (o_pitch_out_c),
        .o_gate_out_a        (o_gate_out_a),
        .o_gate_out_b        (o_gate_out_b),
        .o_gate_out_c        (o_gate_out_c),
        .o_play_step         (o_play_step),
        .o_staging_step      (o_staging_step),
        .o_selected_channel  (o_selected_channel),
        .o_is_running        (o_is_running),
        .o_paste_waiting     (o_paste_waiting),
        .o_edit_allowed      (o_edit_allowed)
    );

endmodule
